FILE: design/dgb_pkg.sv
// dgb_pkg: shared types, codes and defaults for the distance gesture button.
// No dependencies; every other file in the design imports it.
`timescale 1ns / 1ps

package dgb_pkg;

  // Field and register widths
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Defaults for top-level parameters
  localparam int unsigned WINDOW_DEF      = 10;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] SHORT_LIMIT_RST     = 16'd96;
  localparam logic [CFG_DATA_W-1:0] LONG_LIMIT_RST      = 16'd320;
  localparam logic [CFG_DATA_W-1:0] HYSTERESIS_STEP_RST = 16'd16;
  localparam logic [CFG_DATA_W-1:0] IDLE_THRESHOLD_RST  = 16'd3;
  localparam logic [CFG_DATA_W-1:0] VALID_LIMIT_RST     = 16'd640;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_LIMIT     = 3'd0,
    CFG_LONG_LIMIT      = 3'd1,
    CFG_HYSTERESIS_STEP = 3'd2,
    CFG_IDLE_THRESHOLD  = 3'd3,
    CFG_VALID_LIMIT     = 3'd4
  } cfg_idx_e;

  // Gesture classes
  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_SHORT = 2'd1,
    GEST_LONG  = 2'd2
  } gesture_e;

  // Press events
  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_SHORT_PRESS   = 3'd1,
    EV_LONG_PRESS    = 3'd2,
    EV_SHORT_TO_LONG = 3'd3,
    EV_SHORT_RELEASE = 3'd4,
    EV_LONG_TO_SHORT = 3'd5,
    EV_LONG_RELEASE  = 3'd6
  } event_e;

  // Configuration register file contents
  typedef struct packed {
    logic [CFG_DATA_W-1:0] short_limit;
    logic [CFG_DATA_W-1:0] long_limit;
    logic [CFG_DATA_W-1:0] hysteresis_step;
    logic [CFG_DATA_W-1:0] idle_threshold;
    logic [CFG_DATA_W-1:0] valid_limit;
  } cfg_t;

  // Input item
  typedef struct packed {
    logic              reading_ok;
    logic [DIST_W-1:0] distance;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [DIST_W-1:0] average_distance;
    gesture_e          gesture;
    event_e            event_res;
    logic              active;
    logic              in_range;
  } out_item_t;

  // Queue entry: sample already tested against the valid limit
  typedef struct packed {
    logic              in_range;
    logic [DIST_W-1:0] distance;
  } q_item_t;

  // Control that travels with the window sum into the divide stage
  typedef struct packed {
    logic valid;
    logic present;
    logic in_range;
  } stage_ctl_t;

endpackage

FILE: design/dgb_front.sv
// dgb_front: input handshake, in-range test and the short item queue.
// Depends on dgb_pkg.
`timescale 1ns / 1ps

module dgb_front #(
  parameter int unsigned QUEUE_DEPTH = dgb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dgb_pkg::in_item_t               in_item_i,
  input  logic [dgb_pkg::CFG_DATA_W-1:0]  valid_limit_i,
  input  logic                            pop_i,
  output logic                            q_valid_o,
  output dgb_pkg::q_item_t                q_item_o
);
  import dgb_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  q_item_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  q_item_t          push_item;

  // Sample is in range when the sensor delivered it and it is below the limit
  assign push_item.in_range = in_item_i.reading_ok && (in_item_i.distance < valid_limit_i);
  assign push_item.distance = in_item_i.distance;

  assign in_ready_o = (count_q != FULL_CNT);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item;
    end
  end

  // Fill count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue fill count above depth");

endmodule

FILE: design/dgb_window.sv
// dgb_window: averaging window store, running sum and hand-present tracking.
// Depends on dgb_pkg.
`timescale 1ns / 1ps

module dgb_window #(
  parameter int unsigned WINDOW = dgb_pkg::WINDOW_DEF,
  localparam int unsigned SUM_W = dgb_pkg::DIST_W + $clog2(WINDOW)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic                            q_valid_i,
  input  dgb_pkg::q_item_t                q_item_i,
  input  logic [dgb_pkg::CFG_DATA_W-1:0]  idle_threshold_i,
  output logic                            pop_o,
  output dgb_pkg::stage_ctl_t             ctl_o,
  output logic [SUM_W-1:0]                sum_o
);
  import dgb_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [DIST_W-1:0] IDLE_MAX  = '1;

  logic [DIST_W-1:0] store_q [WINDOW];
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              present_q, present_d;
  logic [DIST_W-1:0] idle_q, idle_d;
  logic              valid_q;
  logic              in_range_q;
  logic              do_fill, do_push;
  logic [DIST_W-1:0] fill_val;

  assign pop_o = advance_i && q_valid_i;

  // Window update for one item
  always_comb begin
    sum_d     = sum_q;
    slot_d    = slot_q;
    present_d = present_q;
    idle_d    = idle_q;
    do_fill   = 1'b0;
    do_push   = 1'b0;
    fill_val  = q_item_i.distance;
    if (q_item_i.in_range) begin
      if (present_q) begin
        do_push = 1'b1;
        sum_d   = sum_q - SUM_W'(store_q[slot_q]) + SUM_W'(q_item_i.distance);
        slot_d  = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
      end else begin
        do_fill = 1'b1;
        sum_d   = SUM_W'(q_item_i.distance) * SUM_W'(WINDOW);
      end
      idle_d    = '0;
      present_d = 1'b1;
    end else if (present_q) begin
      // Out-of-range run, saturating
      idle_d = (idle_q != IDLE_MAX) ? idle_q + 1'b1 : idle_q;
      if (idle_d >= idle_threshold_i) begin
        do_fill   = 1'b1;
        fill_val  = '0;
        sum_d     = '0;
        present_d = 1'b0;
      end
    end
  end

  // Window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        store_q[i] <= '0;
      end
      sum_q     <= '0;
      slot_q    <= '0;
      present_q <= 1'b0;
      idle_q    <= '0;
    end else if (pop_o) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (do_fill || (do_push && (slot_q == SLOT_W'(i)))) begin
          store_q[i] <= fill_val;
        end
      end
      sum_q     <= sum_d;
      slot_q    <= slot_d;
      present_q <= present_d;
      idle_q    <= idle_d;
    end
  end

  // Stage valid and the in-range flag of the item now in the sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      in_range_q <= 1'b0;
    end else if (advance_i) begin
      valid_q    <= pop_o;
      in_range_q <= q_item_i.in_range;
    end
  end

  assign ctl_o.valid    = valid_q;
  assign ctl_o.present  = present_q;
  assign ctl_o.in_range = in_range_q;
  assign sum_o          = sum_q;

  // Next slot stays inside the window
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LAST_SLOT)
    else $error("write slot outside window");

  // An idle block holds an all-zero window
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !present_q |-> (sum_q == '0))
    else $error("window sum nonzero while idle");

endmodule

FILE: design/dgb_classify.sv
// dgb_classify: window average by reciprocal multiply, gesture class with
// hysteresis, press state machine and the result register. Depends on dgb_pkg.
`timescale 1ns / 1ps

module dgb_classify #(
  parameter int unsigned WINDOW = dgb_pkg::WINDOW_DEF,
  localparam int unsigned SUM_W = dgb_pkg::DIST_W + $clog2(WINDOW)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dgb_pkg::cfg_t        cfg_i,
  input  dgb_pkg::stage_ctl_t  ctl_i,
  input  logic [SUM_W-1:0]     sum_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dgb_pkg::out_item_t   out_item_o
);
  import dgb_pkg::*;

  // Reciprocal of the window size: estimate is exact or one low
  localparam int unsigned SHIFT  = SUM_W;
  localparam int unsigned PROD_W = SUM_W + SHIFT + 1;
  localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'((64'd1 << SHIFT) / WINDOW);
  localparam logic [SUM_W-1:0] WIN_SUM = SUM_W'(WINDOW);
  localparam int unsigned CMP_W = DIST_W + 2;

  typedef enum logic [1:0] {
    PS_RELEASED = 2'd0,
    PS_SHORT    = 2'd1,
    PS_LONG     = 2'd2
  } press_e;

  // Divide stage registers
  logic [PROD_W-1:0] prod;
  logic              valid2_q;
  logic              present2_q;
  logic              in_range2_q;
  logic [SUM_W-1:0]  sum2_q;
  logic [SUM_W-1:0]  quot_q;

  // Result stage signals
  logic [SUM_W-1:0]        rem;
  logic [SUM_W-1:0]        quot_fix;
  logic [DIST_W-1:0]       avg;
  logic signed [CMP_W-1:0] avg_s, lo_s, hi_s;
  gesture_e                gest;
  event_e                  ev;
  press_e                  press_q, press_d;
  logic [DIST_W-1:0]       widen_q, widen_d;
  logic                    out_valid_q;
  out_item_t               out_item_q;

  assign advance_o = !out_valid_q || out_ready_i;

  // Quotient estimate
  assign prod = PROD_W'(sum_i) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else if (advance_o) begin
      valid2_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      present2_q  <= ctl_i.present;
      in_range2_q <= ctl_i.in_range;
      sum2_q      <= sum_i;
      quot_q      <= prod[SHIFT +: SUM_W];
    end
  end

  // One correction step gives the truncated average
  assign rem      = sum2_q - quot_q * WIN_SUM;
  assign quot_fix = quot_q + SUM_W'(rem >= WIN_SUM);
  assign avg      = quot_fix[DIST_W-1:0];

  // Class limits, low limit may go negative
  assign avg_s = $signed({2'b00, avg});
  assign lo_s  = $signed({2'b00, cfg_i.short_limit}) - $signed({2'b00, widen_q});
  assign hi_s  = $signed({2'b00, cfg_i.long_limit}) + $signed({2'b00, widen_q});

  always_comb begin
    if ((avg_s > 0) && (avg_s < lo_s)) begin
      gest    = GEST_SHORT;
      widen_d = '0;
    end else if ((lo_s < avg_s) && (avg_s < hi_s)) begin
      gest    = GEST_LONG;
      widen_d = cfg_i.hysteresis_step;
    end else begin
      gest    = GEST_NONE;
      widen_d = '0;
    end
  end

  // Press transitions
  always_comb begin
    press_d = press_q;
    ev      = EV_NONE;
    unique case (press_q)
      PS_SHORT: begin
        unique case (gest)
          GEST_SHORT: ev = EV_NONE;
          GEST_LONG: begin
            press_d = PS_LONG;
            ev      = EV_SHORT_TO_LONG;
          end
          default: begin
            press_d = PS_RELEASED;
            ev      = EV_SHORT_RELEASE;
          end
        endcase
      end
      PS_LONG: begin
        unique case (gest)
          GEST_SHORT: begin
            press_d = PS_SHORT;
            ev      = EV_LONG_TO_SHORT;
          end
          GEST_LONG: ev = EV_NONE;
          default: begin
            press_d = PS_RELEASED;
            ev      = EV_LONG_RELEASE;
          end
        endcase
      end
      default: begin
        unique case (gest)
          GEST_SHORT: begin
            press_d = PS_SHORT;
            ev      = EV_SHORT_PRESS;
          end
          GEST_LONG: begin
            press_d = PS_LONG;
            ev      = EV_LONG_PRESS;
          end
          default: begin
            press_d = PS_RELEASED;
            ev      = EV_NONE;
          end
        endcase
      end
    endcase
  end

  // Press state, widening and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q     <= PS_RELEASED;
      widen_q     <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else if (advance_o) begin
      out_valid_q <= valid2_q;
      if (valid2_q) begin
        press_q                     <= press_d;
        widen_q                     <= widen_d;
        out_item_q.average_distance <= avg;
        out_item_q.gesture          <= gest;
        out_item_q.event_res        <= ev;
        out_item_q.active           <= present2_q;
        out_item_q.in_range         <= in_range2_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A short press event always carries the short gesture
  a_press_gesture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_item_q.event_res == EV_SHORT_PRESS)
    |-> (out_item_q.gesture == GEST_SHORT))
    else $error("short press without short gesture");

  // No gesture means no event or a release
  a_none_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_item_q.gesture == GEST_NONE)
    |-> ((out_item_q.event_res == EV_NONE) || (out_item_q.event_res == EV_SHORT_RELEASE)
         || (out_item_q.event_res == EV_LONG_RELEASE)))
    else $error("bad event with no gesture");

endmodule

FILE: design/distance_gesture_button.sv
// distance_gesture_button: top level with the register file, the front queue
// and the back pipeline. Depends on dgb_pkg, dgb_front, dgb_window, dgb_classify.
//
//   Port group    Dir   Handshake           Payload
//   in            in    in_valid/in_ready   in_item_i  (reading_ok, distance)
//   out           out   out_valid/out_ready out_item_o (average, gesture, event, flags)
//   cfg           in    cfg_we_i only       cfg_idx_i, cfg_data_i
//
// One item per cycle while the output is not stalled; an accepted item is registered in
// turn by the queue, window update, reciprocal multiply and classify-and-result stages.
// Window sum and press state loop through one register each, so neither slows the rate.
// Reset clears the window, state and registers to their defaults at once.
// A stalled output freezes the back pipeline; the queue keeps taking items until full.
`timescale 1ns / 1ps

module distance_gesture_button #(
  parameter int unsigned WINDOW      = dgb_pkg::WINDOW_DEF,
  parameter int unsigned QUEUE_DEPTH = dgb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dgb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dgb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dgb_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dgb_pkg::out_item_t              out_item_o
);
  import dgb_pkg::*;

  localparam int unsigned SUM_W = DIST_W + $clog2(WINDOW);

  cfg_t             cfg_q;
  logic             pop;
  logic             q_valid;
  q_item_t          q_item;
  logic             advance;
  stage_ctl_t       win_ctl;
  logic [SUM_W-1:0] win_sum;

  // Configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_limit     <= SHORT_LIMIT_RST;
      cfg_q.long_limit      <= LONG_LIMIT_RST;
      cfg_q.hysteresis_step <= HYSTERESIS_STEP_RST;
      cfg_q.idle_threshold  <= IDLE_THRESHOLD_RST;
      cfg_q.valid_limit     <= VALID_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT_LIMIT:     cfg_q.short_limit     <= cfg_data_i;
        CFG_LONG_LIMIT:      cfg_q.long_limit      <= cfg_data_i;
        CFG_HYSTERESIS_STEP: cfg_q.hysteresis_step <= cfg_data_i;
        CFG_IDLE_THRESHOLD:  cfg_q.idle_threshold  <= cfg_data_i;
        CFG_VALID_LIMIT:     cfg_q.valid_limit     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: in-range test and queue
  dgb_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .valid_limit_i(cfg_q.valid_limit),
    .pop_i        (pop),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item)
  );

  // Back: window update
  dgb_window #(
    .WINDOW(WINDOW)
  ) u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .idle_threshold_i(cfg_q.idle_threshold),
    .pop_o           (pop),
    .ctl_o           (win_ctl),
    .sum_o           (win_sum)
  );

  // Back: average, class and press events
  dgb_classify #(
    .WINDOW(WINDOW)
  ) u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .ctl_i      (win_ctl),
    .sum_i      (win_sum),
    .advance_o  (advance),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
